// ----- sv/sfp_pkg.sv -----
// Package: parse phases, register indexes and the CRC-32 byte table.
package sfp_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0]  FIRST_SYNC_RST = 8'h55;
    localparam logic [7:0]  SECOND_SYNC_RST = 8'hAA;
    localparam logic [15:0] MAX_LEN_RST = 16'd9999;
    localparam logic [31:0] CRC_SEED_RST = 32'h0000_0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SYNC  = 2'd0,
        CFG_SECOND_SYNC = 2'd1,
        CFG_MAX_LEN     = 2'd2,
        CFG_CRC_SEED    = 2'd3
    } cfg_idx_t;

    typedef enum logic [10:0] {
        PH_SYNC1   = 11'h001,
        PH_SYNC2   = 11'h002,
        PH_ID1     = 11'h004,
        PH_ID2     = 11'h008,
        PH_LEN1    = 11'h010,
        PH_LEN2    = 11'h020,
        PH_PAYLOAD = 11'h040,
        PH_CHK1    = 11'h080,
        PH_CHK2    = 11'h100,
        PH_CHK3    = 11'h200,
        PH_CHK4    = 11'h400
    } phase_t;

    typedef logic [31:0] crc_table_t [256];

    function automatic crc_table_t crc_table_gen();
        crc_table_t tbl;
        logic [31:0] acc;
        for (int i = 0; i < 256; i++)
        begin
            acc = 32'(i);
            for (int k = 0; k < 8; k++)
            begin
                acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'h0);
            end
            tbl[i] = acc;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

endpackage

// ----- sv/sfp_if.sv -----
// Request channel interfaces: received bytes, parse results, register writes.
interface sfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        crc_ok;
    logic [15:0] frame_id;
    logic [15:0] frame_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_done, output crc_ok,
                    output frame_id, output frame_length, input ready);
    modport sink (input valid, input payload_valid, input payload_byte,
                  input payload_index, input frame_done, input crc_ok,
                  input frame_id, input frame_length, output ready);
endinterface

interface sfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ----- sv/sfp_crc_step.sv -----
// One byte step of the reflected CRC-32 through the constant table.
module sfp_crc_step
    import sfp_pkg::*;
(
    input  logic [31:0] acc,
    input  logic [7:0]  data,
    output logic [31:0] acc_next
);

    logic [7:0] tbl_idx;

    assign tbl_idx = acc[7:0] ^ data;
    assign acc_next = (acc >> 8) ^ CRC_TABLE[tbl_idx];

endmodule

// ----- sv/sync_frame_parser_crc32_unit.sv -----
// Sync/id/length frame parser with CRC-32 check, top level.
// The result request for an accepted byte is registered and appears in the cycle after the byte is taken.
// Throughput: one byte per cycle; one CRC table step and the phase update per cycle.
// A byte is taken whenever the result register is empty or being drained.
// Reset: hunt phase, id/length/count cleared, CRC accumulator one,
// registers back to 0x55, 0xAA, 9999 and seed one, no result pending.
module sync_frame_parser_crc32_unit
    import sfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sfp_rx_if.sink   rx,
    sfp_res_if.source res,
    sfp_cfg_if.sink  cfg
);

    logic [7:0]  first_sync_reg;
    logic [7:0]  second_sync_reg;
    logic [15:0] max_len_reg;
    logic [31:0] crc_seed_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  id_low_reg, id_low_next;
    logic [15:0] cur_id_reg, cur_id_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] cur_len_reg, cur_len_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [23:0] chk_low_reg, chk_low_next;

    logic        res_valid_reg;
    logic        pv_reg, pv_next;
    logic [7:0]  pb_reg, pb_next;
    logic [15:0] pi_reg, pi_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;

    logic        in_fire;
    logic [7:0]  b;
    logic [31:0] crc_in;
    logic [31:0] crc_step;
    logic [15:0] len_word;
    logic [15:0] count_inc;

    assign b = rx.rx_byte;
    assign rx.ready = !res_valid_reg || res.ready;
    assign in_fire = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign crc_in = (phase_reg == PH_SYNC1) ? crc_seed_reg : crc_reg;
    assign len_word = {b, len_low_reg};
    assign count_inc = count_reg + 16'd1;

    sfp_crc_step u_crc (
        .acc      (crc_in),
        .data     (b),
        .acc_next (crc_step)
    );

    always_comb
    begin
        phase_next = phase_reg;
        id_low_next = id_low_reg;
        cur_id_next = cur_id_reg;
        len_low_next = len_low_reg;
        cur_len_next = cur_len_reg;
        count_next = count_reg;
        crc_next = crc_reg;
        chk_low_next = chk_low_reg;
        pv_next = 1'b0;
        pb_next = 8'h00;
        pi_next = 16'h0000;
        done_next = 1'b0;
        ok_next = 1'b0;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (b == second_sync_reg)
                begin
                    crc_next = crc_step;
                    phase_next = PH_ID1;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_ID1:
            begin
                id_low_next = b;
                crc_next = crc_step;
                phase_next = PH_ID2;
            end
            PH_ID2:
            begin
                cur_id_next = {b, id_low_reg};
                crc_next = crc_step;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_low_next = b;
                crc_next = crc_step;
                phase_next = PH_LEN2;
            end
            PH_LEN2:
            begin
                cur_len_next = len_word;
                crc_next = crc_step;
                if (len_word != 16'd0 && len_word <= max_len_reg)
                begin
                    count_next = 16'd0;
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_PAYLOAD:
            begin
                pv_next = 1'b1;
                pb_next = b;
                pi_next = count_reg;
                crc_next = crc_step;
                count_next = count_inc;
                if (count_inc == cur_len_reg)
                begin
                    phase_next = PH_CHK1;
                end
            end
            PH_CHK1:
            begin
                chk_low_next = {16'h0000, b};
                phase_next = PH_CHK2;
            end
            PH_CHK2:
            begin
                chk_low_next = {8'h00, b, chk_low_reg[7:0]};
                phase_next = PH_CHK3;
            end
            PH_CHK3:
            begin
                chk_low_next = {b, chk_low_reg[15:0]};
                phase_next = PH_CHK4;
            end
            PH_CHK4:
            begin
                done_next = 1'b1;
                ok_next = ({b, chk_low_reg} == crc_reg);
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
                if (b == first_sync_reg)
                begin
                    crc_next = crc_step;
                    phase_next = PH_SYNC2;
                end
            end
        endcase
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg <= FIRST_SYNC_RST;
            second_sync_reg <= SECOND_SYNC_RST;
            max_len_reg <= MAX_LEN_RST;
            crc_seed_reg <= CRC_SEED_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                CFG_FIRST_SYNC:  first_sync_reg <= cfg.data[7:0];
                CFG_SECOND_SYNC: second_sync_reg <= cfg.data[7:0];
                CFG_MAX_LEN:     max_len_reg <= cfg.data[15:0];
                CFG_CRC_SEED:    crc_seed_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            id_low_reg <= 8'h00;
            cur_id_reg <= 16'h0000;
            len_low_reg <= 8'h00;
            cur_len_reg <= 16'h0000;
            count_reg <= 16'h0000;
            crc_reg <= 32'h0000_0001;
            chk_low_reg <= 24'h00_0000;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            id_low_reg <= id_low_next;
            cur_id_reg <= cur_id_next;
            len_low_reg <= len_low_next;
            cur_len_reg <= cur_len_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
            chk_low_reg <= chk_low_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pv_reg <= pv_next;
            pb_reg <= pb_next;
            pi_reg <= pi_next;
            done_reg <= done_next;
            ok_reg <= ok_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.payload_valid = pv_reg;
    assign res.payload_byte = pb_reg;
    assign res.payload_index = pi_reg;
    assign res.frame_done = done_reg;
    assign res.crc_ok = ok_reg;
    assign res.frame_id = cur_id_reg;
    assign res.frame_length = cur_len_reg;

endmodule

// ----- sim/testbench.sv -----
// Testbench for the sync/id/length frame parser: random frames checked against a CRC-32 predictor.
module testbench;
    import sfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic        crc_ok;
        logic [15:0] frame_id;
        logic [15:0] frame_length;
    } parse_result_t;

    logic clk;
    logic rst_n;

    sfp_rx_if  rx_ch ();
    sfp_res_if res_ch ();
    sfp_cfg_if cfg_ch ();

    sync_frame_parser_crc32_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    int unsigned   cycle_count;
    int unsigned   fail_count;
    int unsigned   bytes_sent;
    int unsigned   burst_left;
    bit            steady_send;
    bit            hold_req;
    parse_result_t parse_results_due[$];

    // parser model state and register copies
    logic [7:0]  first_sync_cfg  = FIRST_SYNC_RST;
    logic [7:0]  second_sync_cfg = SECOND_SYNC_RST;
    logic [15:0] max_len_cfg     = MAX_LEN_RST;
    logic [31:0] seed_cfg        = CRC_SEED_RST;
    phase_t      ph              = PH_SYNC1;
    logic [7:0]  id_lo           = '0;
    logic [15:0] cur_id          = '0;
    logic [7:0]  len_lo          = '0;
    logic [15:0] cur_len         = '0;
    logic [15:0] pay_cnt         = '0;
    logic [31:0] crc_acc         = 32'h1;
    logic [23:0] chk_lo          = '0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] a;
        a = acc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction

    function automatic parse_result_t predict_parse(input logic [7:0] b);
        parse_result_t r;
        r = '0;
        case (ph)
            PH_SYNC2:
            begin
                if (b == second_sync_cfg)
                begin
                    crc_acc = crc_step(crc_acc, b);
                    ph = PH_ID1;
                end
                else
                begin
                    ph = PH_SYNC1;
                end
            end
            PH_ID1:
            begin
                id_lo = b;
                crc_acc = crc_step(crc_acc, b);
                ph = PH_ID2;
            end
            PH_ID2:
            begin
                cur_id = {b, id_lo};
                crc_acc = crc_step(crc_acc, b);
                ph = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_lo = b;
                crc_acc = crc_step(crc_acc, b);
                ph = PH_LEN2;
            end
            PH_LEN2:
            begin
                cur_len = {b, len_lo};
                crc_acc = crc_step(crc_acc, b);
                if (cur_len != 0 && cur_len <= max_len_cfg)
                begin
                    pay_cnt = '0;
                    ph = PH_PAYLOAD;
                end
                else
                begin
                    ph = PH_SYNC1;
                end
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte = b;
                r.payload_index = pay_cnt;
                crc_acc = crc_step(crc_acc, b);
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt == cur_len)
                begin
                    ph = PH_CHK1;
                end
            end
            PH_CHK1:
            begin
                chk_lo = {16'h0, b};
                ph = PH_CHK2;
            end
            PH_CHK2:
            begin
                chk_lo[15:8] = b;
                ph = PH_CHK3;
            end
            PH_CHK3:
            begin
                chk_lo[23:16] = b;
                ph = PH_CHK4;
            end
            PH_CHK4:
            begin
                r.frame_done = 1'b1;
                r.crc_ok = ({b, chk_lo} == crc_acc);
                ph = PH_SYNC1;
            end
            default:
            begin
                ph = PH_SYNC1;
                if (b == first_sync_cfg)
                begin
                    crc_acc = crc_step(seed_cfg, b);
                    ph = PH_SYNC2;
                end
            end
        endcase
        r.frame_id = cur_id;
        r.frame_length = cur_len;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // compare result requests first, then model the byte taken at this edge
    always @(posedge clk)
    begin
        parse_result_t got;
        parse_result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.payload_valid = res_ch.payload_valid;
                got.payload_byte  = res_ch.payload_byte;
                got.payload_index = res_ch.payload_index;
                got.frame_done    = res_ch.frame_done;
                got.crc_ok        = res_ch.crc_ok;
                got.frame_id      = res_ch.frame_id;
                got.frame_length  = res_ch.frame_length;
                if (parse_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result at cycle %0d", cycle_count);
                end
                else
                begin
                    want = parse_results_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  exp pv=%0d b=%h i=%0d done=%0d ok=%0d id=%h len=%0d",
                                     want.payload_valid, want.payload_byte,
                                     want.payload_index, want.frame_done, want.crc_ok,
                                     want.frame_id, want.frame_length);
                            $display("  got pv=%0d b=%h i=%0d done=%0d ok=%0d id=%h len=%0d",
                                     got.payload_valid, got.payload_byte,
                                     got.payload_index, got.frame_done, got.crc_ok,
                                     got.frame_id, got.frame_length);
                        end
                    end
                end
            end
            if (rx_ch.valid && rx_ch.ready)
                parse_results_due.push_back(predict_parse(rx_ch.rx_byte));
        end
    end

    // result side: rotating stall pattern, plus a long hold-off on request
    always @(negedge clk)
    begin
        logic [15:0] stall_pat;
        int unsigned pat_age;
        int unsigned hold_left;
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            res_ch.ready = 1'b0;
            hold_left--;
        end
        else
        begin
            if (pat_age == 0)
            begin
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
                pat_age = $urandom_range(20, 80);
            end
            res_ch.ready = stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_age--;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                @(negedge clk);
                rx_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        rx_ch.valid = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // cut < 0 sends the whole frame, otherwise only its first cut bytes
    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input bit bad_crc, input int cut);
        logic [7:0]  fb[$];
        logic [31:0] c;
        fb.push_back(first_sync_cfg);
        fb.push_back(second_sync_cfg);
        fb.push_back(id[7:0]);
        fb.push_back(id[15:8]);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        if (len != 0 && len <= max_len_cfg)
        begin
            repeat (len) fb.push_back(8'($urandom));
            c = seed_cfg;
            foreach (fb[i])
                c = crc_step(c, fb[i]);
            if (bad_crc)
                c = c ^ (32'h1 << $urandom_range(0, 31));
            for (int i = 0; i < 4; i++)
                fb.push_back(c[8*i +: 8]);
        end
        foreach (fb[i])
        begin
            if (cut < 0 || i < cut)
                send_byte(fb[i]);
        end
    endtask

    function automatic logic [15:0] pick_len();
        int unsigned top;
        top = (max_len_cfg == 0) ? 1 : max_len_cfg;
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(1, (top < 40) ? top : 40));
        return 16'($urandom_range(1, (top < 8) ? top : 8));
    endfunction

    function automatic logic [15:0] over_len();
        int unsigned l;
        if (max_len_cfg == 16'hFFFF)
            return 16'h0;
        l = max_len_cfg + $urandom_range(1, 3);
        return (l > 65535) ? 16'hFFFF : 16'(l);
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned stop;
        int unsigned r;
        logic [15:0] len;
        stop = bytes_sent + n;
        while (bytes_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                send_frame(16'($urandom), pick_len(), $urandom_range(0, 5) == 0, -1);
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? first_sync_cfg : 8'($urandom));
            end
            else if (r < 88)
            begin
                len = pick_len();
                send_frame(16'($urandom), len, 1'b0, $urandom_range(1, len + 9));
            end
            else if (r < 94)
            begin
                send_frame(16'($urandom), 16'h0, 1'b0, -1);
            end
            else
            begin
                send_frame(16'($urandom), over_len(), 1'b0, -1);
            end
        end
    endtask

    // drop valid and wait for every outstanding result, then for the pipeline
    task automatic settle();
        @(negedge clk);
        rx_ch.valid = 1'b0;
        burst_left = 0;
        while (parse_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.data = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_FIRST_SYNC:  first_sync_cfg = value[7:0];
            CFG_SECOND_SYNC: second_sync_cfg = value[7:0];
            CFG_MAX_LEN:     max_len_cfg = value[15:0];
            CFG_CRC_SEED:    seed_cfg = value;
            default:         ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] f, input logic [31:0] s,
                              input logic [31:0] m, input logic [31:0] seed);
        settle();
        write_reg(CFG_FIRST_SYNC, f);
        write_reg(CFG_SECOND_SYNC, s);
        write_reg(CFG_MAX_LEN, m);
        write_reg(CFG_CRC_SEED, seed);
    endtask

    // reset values; repeated first sync is not taken as a new start
    task automatic test_defaults();
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'hFFFF, 16'd1, 1'b0, -1);
        send_frame(16'h0000, 16'd0, 1'b0, -1);
        run_random(200);
    endtask

    task automatic test_length_limits();
        set_config(32'h00, 32'hFF, 32'd1, 32'h0);
        send_frame(16'h1234, 16'd1, 1'b0, -1);
        send_frame(16'hABCD, 16'd2, 1'b0, -1);
        send_frame(16'h8001, 16'd1, 1'b1, -1);
        run_random(150);
    endtask

    task automatic test_wide_settings();
        set_config(32'hFF, 32'h00, 32'hFFFF, 32'hFFFF_FFFF);
        run_random(200);
    endtask

    task automatic test_max_zero();
        set_config(32'h55, 32'hAA, 32'h0, $urandom);
        run_random(80);
    endtask

    // masked upper data bits, and a run where both sync values match
    task automatic test_random_settings();
        logic [31:0] f;
        for (int i = 0; i < 3; i++)
        begin
            f = $urandom;
            set_config(f, (i == 2) ? f : $urandom,
                       {16'($urandom), 16'($urandom_range(1, 64))}, $urandom);
            run_random(90);
        end
    endtask

    task automatic test_backpressure();
        set_config(32'h55, 32'hAA, 32'd9999, 32'h1);
        hold_req = 1'b1;
        steady_send = 1'b1;
        burst_left = 0;
        repeat (3) send_frame(16'($urandom), 16'd4, 1'b0, -1);
        steady_send = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = CFG_FIRST_SYNC;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_length_limits();
        test_wide_settings();
        test_max_zero();
        test_random_settings();
        test_backpressure();

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
